[sv/mexp_pkg.sv]
// Shared constants, types and state encodings for the modular exponentiation block.
package mexp_pkg;

  localparam int unsigned EXP_WIDTH  = 63;
  localparam int unsigned MOD_WIDTH  = 31;
  localparam int unsigned PROD_WIDTH = 2 * MOD_WIDTH;
  // two quotient bits retired per cycle
  localparam int unsigned DIV_STEPS  = PROD_WIDTH / 2;
  localparam int unsigned CNT_WIDTH  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam logic [MOD_WIDTH-1:0] MODULUS_RESET = MOD_WIDTH'(64'd1000000007);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_SQR
  } seq_state_e;

  typedef enum logic {
    MM_IDLE,
    MM_DIV
  } mm_state_e;

  // response of the shared multiply-reduce unit
  typedef struct packed {
    logic                 done;
    logic [MOD_WIDTH-1:0] value;
  } mm_rsp_t;

endpackage

[sv/mexp_mulmod.sv]
// Shared multiply-reduce unit: one product, then restoring reduction two bits a cycle.
module mexp_mulmod (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [mexp_pkg::MOD_WIDTH-1:0]   op_a_i,
  input  logic [mexp_pkg::MOD_WIDTH-1:0]   op_b_i,
  input  logic [mexp_pkg::MOD_WIDTH-1:0]   modulus_i,
  output mexp_pkg::mm_rsp_t                rsp_o
);

  mexp_pkg::mm_state_e                  state_q, state_d;
  logic [mexp_pkg::CNT_WIDTH-1:0]       cnt_q, cnt_d;
  logic                                 done_q, done_d;
  logic [mexp_pkg::PROD_WIDTH-1:0]      prod_q, prod_d;
  logic [mexp_pkg::MOD_WIDTH-1:0]       rem_q, rem_d;

  logic [mexp_pkg::MOD_WIDTH:0]         mod_ext, t1, t2;
  logic [mexp_pkg::MOD_WIDTH-1:0]       r1, r2;

  // A zero modulus never fails the compare, so the remainder just keeps the
  // low bits of the product: arithmetic modulo 2^MOD_WIDTH.
  always_comb begin
    mod_ext = {1'b0, modulus_i};
    t1 = {rem_q, prod_q[mexp_pkg::PROD_WIDTH-1]};
    r1 = (t1 >= mod_ext) ? mexp_pkg::MOD_WIDTH'(t1 - mod_ext)
                         : mexp_pkg::MOD_WIDTH'(t1);
    t2 = {r1, prod_q[mexp_pkg::PROD_WIDTH-2]};
    r2 = (t2 >= mod_ext) ? mexp_pkg::MOD_WIDTH'(t2 - mod_ext)
                         : mexp_pkg::MOD_WIDTH'(t2);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    prod_d  = prod_q;
    rem_d   = rem_q;
    unique case (state_q)
      mexp_pkg::MM_IDLE: begin
        if (start_i) begin
          prod_d  = mexp_pkg::PROD_WIDTH'(op_a_i) * mexp_pkg::PROD_WIDTH'(op_b_i);
          rem_d   = '0;
          cnt_d   = mexp_pkg::CNT_WIDTH'(mexp_pkg::DIV_STEPS - 1);
          state_d = mexp_pkg::MM_DIV;
        end
      end
      mexp_pkg::MM_DIV: begin
        rem_d  = r2;
        prod_d = prod_q << 2;
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = mexp_pkg::MM_IDLE;
        end
      end
      default: state_d = mexp_pkg::MM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mexp_pkg::MM_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = rem_q;

endmodule

[sv/mexp_seq.sv]
// Square-and-multiply sequencer driving the shared multiply-reduce unit.
module mexp_seq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [mexp_pkg::MOD_WIDTH-1:0]   base_value_i,
  input  logic [mexp_pkg::EXP_WIDTH-1:0]   exponent_i,
  output logic                             mm_start_o,
  output logic [mexp_pkg::MOD_WIDTH-1:0]   mm_op_a_o,
  output logic [mexp_pkg::MOD_WIDTH-1:0]   mm_op_b_o,
  input  mexp_pkg::mm_rsp_t                mm_rsp_i,
  output logic [mexp_pkg::MOD_WIDTH-1:0]   residue_o,
  output logic                             residue_valid_o
);

  mexp_pkg::seq_state_e                 state_q, state_d;
  logic [mexp_pkg::MOD_WIDTH-1:0]       acc_q, acc_d;
  logic [mexp_pkg::MOD_WIDTH-1:0]       pow_q, pow_d;
  logic [mexp_pkg::EXP_WIDTH-1:0]       exp_q, exp_d;
  logic [mexp_pkg::MOD_WIDTH-1:0]       res_q, res_d;
  logic                                 valid_q, valid_d;

  always_comb begin
    state_d    = state_q;
    acc_d      = acc_q;
    pow_d      = pow_q;
    exp_d      = exp_q;
    res_d      = res_q;
    valid_d    = 1'b0;
    mm_start_o = 1'b0;
    mm_op_a_o  = pow_q;
    mm_op_b_o  = pow_q;
    unique case (state_q)
      mexp_pkg::ST_IDLE: begin
        if (start) begin
          acc_d   = mexp_pkg::MOD_WIDTH'(1);
          pow_d   = base_value_i;
          exp_d   = exponent_i;
          state_d = mexp_pkg::ST_CHECK;
        end
      end
      mexp_pkg::ST_CHECK: begin
        if (exp_q == '0) begin
          res_d   = acc_q;
          valid_d = 1'b1;
          state_d = mexp_pkg::ST_IDLE;
        end else if (exp_q[0]) begin
          mm_start_o = 1'b1;
          mm_op_a_o  = acc_q;
          state_d    = mexp_pkg::ST_MUL;
        end else begin
          mm_start_o = 1'b1;
          state_d    = mexp_pkg::ST_SQR;
        end
      end
      mexp_pkg::ST_MUL: begin
        if (mm_rsp_i.done) begin
          acc_d      = mm_rsp_i.value;
          mm_start_o = 1'b1;
          state_d    = mexp_pkg::ST_SQR;
        end
      end
      mexp_pkg::ST_SQR: begin
        if (mm_rsp_i.done) begin
          pow_d   = mm_rsp_i.value;
          exp_d   = exp_q >> 1;
          state_d = mexp_pkg::ST_CHECK;
        end
      end
      default: state_d = mexp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mexp_pkg::ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    pow_q <= pow_d;
    exp_q <= exp_d;
    res_q <= res_d;
  end

  assign busy            = (state_q != mexp_pkg::ST_IDLE);
  assign residue_o       = res_q;
  assign residue_valid_o = valid_q;

endmodule

[sv/modular_exponentiation.sv]
// Top level of the modular exponentiation block: modulus register, sequencer, shared unit.
//
//  channel   direction  transfer when                 payload
//  --------  ---------  ----------------------------  ------------------------------
//  request   in         start high, busy low          base_value_i, exponent_i
//  result    out        residue_valid_o high          residue_o
//  modulus   in         modulus_we_i high             modulus_wdata_i
//
// Steps: one square-and-multiply step per exponent bit, up to the highest set
//   bit. Each pass through the shared multiply-reduce unit is a launch, then the
//   restoring reduction, and the sequencer takes the value on the unit's
//   registered done strobe. On a set bit the multiply's result cycle also
//   launches the square.
// The shared multiply-reduce unit sets the pace; busy stays high throughout.
// Reset: asynchronous, active low; the modulus returns to 1000000007.
// Stalls: none on the result side; the strobe lasts a single cycle.
module modular_exponentiation (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [mexp_pkg::MOD_WIDTH-1:0]   base_value_i,
  input  logic [mexp_pkg::EXP_WIDTH-1:0]   exponent_i,
  input  logic                             modulus_we_i,
  input  logic [mexp_pkg::MOD_WIDTH-1:0]   modulus_wdata_i,
  output logic [mexp_pkg::MOD_WIDTH-1:0]   residue_o,
  output logic                             residue_valid_o
);

  logic [mexp_pkg::MOD_WIDTH-1:0] modulus_q, modulus_d;
  logic                           mm_start;
  logic [mexp_pkg::MOD_WIDTH-1:0] mm_op_a, mm_op_b;
  mexp_pkg::mm_rsp_t              mm_rsp;

  // Modulus register, to be written only while idle, which the block leaves to the
  // user; a zero value gives wrap-around arithmetic modulo 2^31 in the reduction unit.
  always_comb begin
    modulus_d = modulus_we_i ? modulus_wdata_i : modulus_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= mexp_pkg::MODULUS_RESET;
    end else begin
      modulus_q <= modulus_d;
    end
  end

  // Sequencer: walks the exponent from the LSB, multiply on a set bit,
  // square on every bit, and finishes once no set bits remain.
  mexp_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .base_value_i    (base_value_i),
    .exponent_i      (exponent_i),
    .mm_start_o      (mm_start),
    .mm_op_a_o       (mm_op_a),
    .mm_op_b_o       (mm_op_b),
    .mm_rsp_i        (mm_rsp),
    .residue_o       (residue_o),
    .residue_valid_o (residue_valid_o)
  );

  // Shared 31x31 multiplier followed by a two-bit-per-cycle restoring reduction.
  mexp_mulmod u_mulmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mm_start),
    .op_a_i    (mm_op_a),
    .op_b_i    (mm_op_b),
    .modulus_i (modulus_q),
    .rsp_o     (mm_rsp)
  );

endmodule

[sv/mexp_checker.sv]
// Port-level checks for the modular exponentiation block, bound to the top level.
module mexp_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic [mexp_pkg::EXP_WIDTH-1:0]   exponent_i,
  input logic [mexp_pkg::MOD_WIDTH-1:0]   residue_o,
  input logic                             residue_valid_o
);

  // an accepted request makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after request transfer");

  // the result strobe comes out as the block drops back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    residue_valid_o |-> !busy)
    else $error("result strobe while still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> residue_valid_o)
    else $error("busy dropped without a result");

  // zero exponent: residue of one, with no multiply-reduce pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && exponent_i == '0) |=> ##1
      (residue_valid_o && residue_o == mexp_pkg::MOD_WIDTH'(1)))
    else $error("zero exponent did not give residue one");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .exponent_i      (exponent_i),
  .residue_o       (residue_o),
  .residue_valid_o (residue_valid_o)
);

[tb/modular_exponentiation_tb.sv]
// Self-checking testbench for modular_exponentiation: random and directed requests, predicted residues.
`timescale 1ns / 1ps

module modular_exponentiation_tb;

  localparam int unsigned   EXP_WIDTH    = mexp_pkg::EXP_WIDTH;
  localparam int unsigned   MOD_WIDTH    = mexp_pkg::MOD_WIDTH;
  localparam logic [MOD_WIDTH-1:0] MODULUS_RESET = mexp_pkg::MODULUS_RESET;
  localparam int unsigned   HALF_PERIOD  = 5;
  localparam int unsigned   RESET_CYCLES = 9;
  // quiet cycles after the last residue before a modulus write or the verdict
  localparam int unsigned   SETTLE       = 16;
  localparam int unsigned   REPORT_MAX   = 10;
  localparam logic [63:0]   MOD_MASK     = (64'd1 << MOD_WIDTH) - 64'd1;
  localparam logic [MOD_WIDTH-1:0] MOD_MAX = '1;
  localparam logic [EXP_WIDTH-1:0] EXP_MAX = '1;

  typedef struct {
    logic [MOD_WIDTH-1:0] base;
    logic [EXP_WIDTH-1:0] expo;
  } request_t;

  // a residue still owed by the block, kept with its operands for reporting
  typedef struct {
    logic [MOD_WIDTH-1:0] base;
    logic [EXP_WIDTH-1:0] expo;
    logic [MOD_WIDTH-1:0] residue;
  } residue_due_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [MOD_WIDTH-1:0] base_value = '0;
  logic [EXP_WIDTH-1:0] exponent = '0;
  logic                 modulus_we = 1'b0;
  logic [MOD_WIDTH-1:0] modulus_wdata = '0;
  logic [MOD_WIDTH-1:0] residue;
  logic                 residue_valid;

  request_t             request_q[$];
  residue_due_t         residue_due_q[$];
  logic [MOD_WIDTH-1:0] modulus_now = MODULUS_RESET;
  int unsigned          gap_pct = 0;
  int unsigned          fail_count = 0;
  // high when the request on the ports transferred at the last rising edge
  logic                 req_fire = 1'b0;

  modular_exponentiation u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .base_value_i    (base_value),
    .exponent_i      (exponent),
    .modulus_we_i    (modulus_we),
    .modulus_wdata_i (modulus_wdata),
    .residue_o       (residue),
    .residue_valid_o (residue_valid)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Predicted residue: square-and-multiply from the exponent LSB upward.
  // The base goes in unreduced; products stay below 2^62, so 64 bits are exact.
  // A zero modulus (never written here) would wrap at MOD_WIDTH bits.
  function automatic logic [MOD_WIDTH-1:0] power_mod(logic [MOD_WIDTH-1:0] base_in,
                                                     logic [EXP_WIDTH-1:0] expo_in,
                                                     logic [MOD_WIDTH-1:0] modulus);
    logic [63:0] acc;
    logic [63:0] pw;
    logic [63:0] bits;
    acc  = 64'd1;
    pw   = 64'(base_in);
    bits = 64'(expo_in);
    for (int i = 0; i < EXP_WIDTH && bits != 64'd0; i++) begin
      if (bits[0]) begin
        acc = acc * pw;
        acc = (modulus == '0) ? (acc & MOD_MASK) : (acc % 64'(modulus));
      end
      pw   = pw * pw;
      pw   = (modulus == '0) ? (pw & MOD_MASK) : (pw % 64'(modulus));
      bits = bits >> 1;
    end
    return acc[MOD_WIDTH-1:0];
  endfunction

  // Driver: presents queued requests at the falling edge. A new request goes
  // out when the port is empty or the last one has just transferred; gap_pct
  // holds start low at random, also while the block is busy.
  always @(negedge clk_i) begin
    request_t req;
    if (rst_ni && (!start || req_fire)) begin
      if (request_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        req        = request_q.pop_front();
        base_value <= req.base;
        exponent   <= req.expo;
        start      <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each strobed residue against the oldest one owed, then
  // records the request that transfers at this edge. Checking first keeps the
  // queue order right should both happen at once.
  always @(posedge clk_i) begin
    residue_due_t due;
    residue_due_t owed;
    if (rst_ni) begin
      if (residue_valid) begin
        if (residue_due_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("%0t: residue 0x%08h with none owed", $realtime, residue);
        end else begin
          owed = residue_due_q.pop_front();
          if (residue !== owed.residue) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("%0t: base 0x%08h exp 0x%016h: expected residue 0x%08h, got 0x%08h",
                       $realtime, owed.base, owed.expo, owed.residue, residue);
          end
        end
      end
      if (start && !busy) begin
        due.base    = base_value;
        due.expo    = exponent;
        due.residue = power_mod(base_value, exponent, modulus_now);
        residue_due_q = {residue_due_q, due};
      end
      req_fire <= start && !busy;
    end
  end

  task automatic push_request(logic [MOD_WIDTH-1:0] base, logic [EXP_WIDTH-1:0] expo);
    request_t req;
    req.base = base;
    req.expo = expo;
    request_q = {request_q, req};
  endtask

  // Random requests. Most exponents are short to keep the run brisk; a
  // quarter span up to the full 63 bits.
  task automatic push_random(int unsigned count);
    logic [63:0]          expo;
    logic [MOD_WIDTH-1:0] base;
    int unsigned          w;
    repeat (count) begin
      w    = ($urandom_range(3) == 0) ? $urandom_range(21, 63) : $urandom_range(0, 20);
      expo = {$urandom, $urandom};
      expo = expo & ((64'd1 << w) - 64'd1);
      case ($urandom_range(5))
        0:       base = MOD_WIDTH'($urandom_range(0, 3));
        1:       base = MOD_MAX - MOD_WIDTH'($urandom_range(0, 3));
        // around the modulus: exercises the unreduced base
        2:       base = modulus_now + MOD_WIDTH'($urandom_range(0, 2)) - MOD_WIDTH'(1);
        3:       base = MOD_WIDTH'($urandom_range(0, 1000));
        default: base = MOD_WIDTH'($urandom);
      endcase
      push_request(base, expo[EXP_WIDTH-1:0]);
    end
  endtask

  // Waits until every request has transferred, every residue has come back
  // and the block has gone idle, then waits out the SETTLE quiet period.
  task automatic drain();
    while (request_q.size() != 0 || start || residue_due_q.size() != 0 || busy)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Modulus write: one cycle of the write enable, only ever while idle.
  task automatic write_modulus(logic [MOD_WIDTH-1:0] value);
    @(negedge clk_i);
    modulus_we    <= 1'b1;
    modulus_wdata <= value;
    @(negedge clk_i);
    modulus_we    <= 1'b0;
    modulus_now    = value;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset modulus, no gaps: field extremes, 0^0, bit patterns,
    // and a base above the modulus.
    gap_pct = 0;
    push_request('0, '0);
    push_request(MOD_MAX, '0);
    push_request('0, EXP_MAX);
    push_request(MOD_MAX, EXP_MAX);
    push_request(MOD_WIDTH'(1), EXP_MAX);
    push_request(MOD_WIDTH'(2), EXP_WIDTH'(1));
    push_request(MOD_MAX, EXP_WIDTH'(1));
    push_request(MOD_WIDTH'(2), EXP_WIDTH'(62));
    push_request(MOD_WIDTH'(3), {1'b1, {(EXP_WIDTH-1){1'b0}}});
    push_request(MOD_WIDTH'(31'h5555_5555), EXP_WIDTH'({EXP_WIDTH{2'b01}}));
    push_request(MOD_WIDTH'(31'h2AAA_AAAA), EXP_WIDTH'({EXP_WIDTH{2'b10}}));
    push_request(MODULUS_RESET, EXP_WIDTH'(5));
    push_request(MODULUS_RESET + MOD_WIDTH'(1), EXP_WIDTH'(1000));
    push_request(MODULUS_RESET - MOD_WIDTH'(1), EXP_WIDTH'(2));
    drain();

    // largest modulus, sender idle half the time
    write_modulus(MOD_MAX);
    gap_pct = 49;
    push_request(MOD_MAX, EXP_MAX);
    push_request(MOD_MAX - MOD_WIDTH'(1), EXP_WIDTH'(3));
    push_random(18);
    drain();

    // modulus one: zero exponent still gives 1, any other gives 0
    write_modulus(MOD_WIDTH'(1));
    gap_pct = 20;
    push_request(MOD_WIDTH'(5), '0);
    push_request('0, '0);
    push_request(MOD_WIDTH'(5), EXP_WIDTH'(1));
    push_request(MOD_MAX, EXP_MAX);
    push_random(8);
    drain();

    write_modulus(MOD_WIDTH'(2));
    gap_pct = 0;
    push_random(12);
    drain();

    write_modulus(MOD_WIDTH'($urandom_range(3, 32'h7FFF_FFFF)));
    gap_pct = 49;
    push_random(30);
    drain();

    // reset value written back explicitly
    write_modulus(MODULUS_RESET);
    gap_pct = 20;
    push_random(30);
    drain();

    write_modulus(MOD_WIDTH'($urandom_range(3, 1000)));
    gap_pct = 0;
    push_random(25);
    drain();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run (every exponent full width).
  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
sv/mexp_pkg.sv
sv/mexp_mulmod.sv
sv/mexp_seq.sv
sv/modular_exponentiation.sv
sv/mexp_checker.sv
tb/modular_exponentiation_tb.sv
